FILE: sv/pitr_pkg.sv
// Shared types, register map and color tables for the palette lookup block.
package pitr_pkg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // Palette mode codes.
    localparam logic [1:0] MODE_GRAY  = 2'd0;
    localparam logic [1:0] MODE_SEPIA = 2'd1;
    localparam logic [1:0] MODE_VGA   = 2'd2;
    localparam logic [1:0] MODE_CUBE  = 2'd3;

    // Register indexes (byte address bit 2 selects the word).
    localparam logic REG_PALETTE_MODE = 1'b0;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    function automatic rgb_t cga_color(input logic [3:0] idx);
        rgb_t c;
        case (idx)
            4'd0:  c = '{8'd0,   8'd0,   8'd0};
            4'd1:  c = '{8'd0,   8'd0,   8'd170};
            4'd2:  c = '{8'd0,   8'd170, 8'd0};
            4'd3:  c = '{8'd0,   8'd170, 8'd170};
            4'd4:  c = '{8'd170, 8'd0,   8'd0};
            4'd5:  c = '{8'd170, 8'd0,   8'd170};
            4'd6:  c = '{8'd170, 8'd85,  8'd0};
            4'd7:  c = '{8'd170, 8'd170, 8'd170};
            4'd8:  c = '{8'd85,  8'd85,  8'd85};
            4'd9:  c = '{8'd85,  8'd85,  8'd255};
            4'd10: c = '{8'd85,  8'd255, 8'd85};
            4'd11: c = '{8'd85,  8'd255, 8'd255};
            4'd12: c = '{8'd255, 8'd85,  8'd85};
            4'd13: c = '{8'd255, 8'd85,  8'd255};
            4'd14: c = '{8'd255, 8'd255, 8'd85};
            default: c = '{8'd255, 8'd255, 8'd255};
        endcase
        return c;
    endfunction

    function automatic rgb_t sys_color(input logic [3:0] idx);
        rgb_t c;
        case (idx)
            4'd0: c = '{8'd192, 8'd192, 8'd192};
            4'd1: c = '{8'd128, 8'd128, 8'd128};
            4'd2: c = '{8'd255, 8'd0,   8'd0};
            4'd3: c = '{8'd0,   8'd255, 8'd0};
            4'd4: c = '{8'd0,   8'd0,   8'd255};
            4'd5: c = '{8'd255, 8'd255, 8'd0};
            4'd6: c = '{8'd255, 8'd0,   8'd255};
            4'd7: c = '{8'd0,   8'd255, 8'd255};
            4'd8: c = '{8'd255, 8'd255, 8'd255};
            default: c = '{8'd0, 8'd0, 8'd0};
        endcase
        return c;
    endfunction

    // Gray ramp: 17 + (step * 238) / 13.
    function automatic logic [7:0] gray_level(input logic [3:0] step);
        logic [7:0] g;
        case (step)
            4'd0:  g = 8'd17;
            4'd1:  g = 8'd35;
            4'd2:  g = 8'd53;
            4'd3:  g = 8'd71;
            4'd4:  g = 8'd90;
            4'd5:  g = 8'd108;
            4'd6:  g = 8'd126;
            4'd7:  g = 8'd145;
            4'd8:  g = 8'd163;
            4'd9:  g = 8'd181;
            4'd10: g = 8'd200;
            4'd11: g = 8'd218;
            4'd12: g = 8'd236;
            default: g = 8'd255;
        endcase
        return g;
    endfunction

endpackage

FILE: sv/palette_index_to_rgb.sv
// Top level: palette lookup with APB mode register and a two-stage beat pipeline.
//
// palette_index_to_rgb translates one 8-bit color index per beat into 8-bit
// red, green and blue under the palette selected by palette_mode (APB byte
// address 0): 0 grayscale, 1 sepia, 2 CGA then 3-3-2, 3 CGA, 6x6x6 cube, gray
// ramp and system colors. The block accepts one index every cycle while
// s_ready is high; each beat moves from the input register into the result
// register, with the lookup logic between them. A stalled result holds in the
// result register; the input register takes at most one more beat behind it
// and then drops s_ready until m_ready returns, so throughput stays at one
// beat per cycle whenever m_ready is high. Write palette_mode only while no
// beat is in flight.
module palette_index_to_rgb (
    input  logic                          aclk,
    input  logic                          aresetn,
    // APB configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pitr_pkg::ADDR_W-1:0]   paddr,
    input  logic [pitr_pkg::DATA_W-1:0]   pwdata,
    output logic [pitr_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    // index input
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_color_index,
    // color output
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_red,
    output logic [7:0]                    m_green,
    output logic [7:0]                    m_blue
);

    logic [1:0]     mode_reg;
    logic [1:0]     mode_next;
    logic           idx_valid_reg;
    logic           idx_valid_next;
    logic [7:0]     idx_reg;
    logic           rgb_valid_reg;
    logic           rgb_valid_next;
    pitr_pkg::rgb_t rgb_reg;
    pitr_pkg::rgb_t lookup_rgb;
    logic           stage2_ready;
    logic           cfg_write;

    // APB: always ready, write lands on the access cycle.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == pitr_pkg::REG_PALETTE_MODE)
                       ? {{(pitr_pkg::DATA_W-2){1'b0}}, mode_reg}
                       : '0;

    always_comb begin
        mode_next = mode_reg;
        if (cfg_write && paddr[2] == pitr_pkg::REG_PALETTE_MODE) begin
            mode_next = pwdata[1:0];
        end
    end

    // Result stage frees up when empty or when its beat leaves this cycle;
    // input stage frees up when empty or when it can advance.
    assign stage2_ready = !rgb_valid_reg || m_ready;
    assign s_ready      = !idx_valid_reg || stage2_ready;

    always_comb begin
        idx_valid_next = idx_valid_reg;
        if (s_ready) begin
            idx_valid_next = s_valid;
        end
        rgb_valid_next = rgb_valid_reg;
        if (stage2_ready) begin
            rgb_valid_next = idx_valid_reg;
        end
    end

    pitr_lookup u_lookup (
        .mode        (mode_reg),
        .color_index (idx_reg),
        .rgb         (lookup_rgb)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= pitr_pkg::MODE_GRAY;
            idx_valid_reg <= 1'b0;
            rgb_valid_reg <= 1'b0;
        end else begin
            mode_reg      <= mode_next;
            idx_valid_reg <= idx_valid_next;
            rgb_valid_reg <= rgb_valid_next;
        end
    end

    // Payload: load on advance, hold otherwise.
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            idx_reg <= s_color_index;
        end
        if (stage2_ready && idx_valid_reg) begin
            rgb_reg <= lookup_rgb;
        end
    end

    assign m_valid = rgb_valid_reg;
    assign m_red   = rgb_reg.red;
    assign m_green = rgb_reg.green;
    assign m_blue  = rgb_reg.blue;

    // A draining output never blocks the input.
    a_no_input_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output drains");

    // An accepted index occupies the input stage next cycle.
    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> idx_valid_reg)
        else $error("accepted beat lost");

    // A beat in the input stage with a blocked result stage stays put.
    a_stage1_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (idx_valid_reg && !stage2_ready) |=> (idx_valid_reg && $stable(idx_reg)))
        else $error("stalled index dropped or changed");

    // A beat in the input stage reaches the result stage when it advances.
    a_stage1_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        (idx_valid_reg && stage2_ready) |=> rgb_valid_reg)
        else $error("index did not reach result stage");

endmodule

FILE: sv/pitr_lookup.sv
// Combinational index-to-color translation for all four palette modes.
module pitr_lookup (
    input  logic [1:0]    mode,
    input  logic [7:0]    color_index,
    output pitr_pkg::rgb_t rgb
);

    logic [7:0] k;          // cube offset, index - 16
    logic [2:0] cube_r;
    logic [5:0] rem36;
    logic [2:0] cube_g;
    logic [2:0] cube_b;
    logic [7:0] gray;
    logic [3:0] gray_step;
    logic [3:0] sys_idx;

    assign k         = color_index - 8'd16;
    assign gray_step = 4'(color_index - 8'd232);
    assign sys_idx   = 4'(color_index - 8'd246);
    assign gray      = pitr_pkg::gray_level(gray_step);

    // Split the cube offset into base-6 digits with compare chains.
    always_comb begin
        if (k >= 8'd180)      cube_r = 3'd5;
        else if (k >= 8'd144) cube_r = 3'd4;
        else if (k >= 8'd108) cube_r = 3'd3;
        else if (k >= 8'd72)  cube_r = 3'd2;
        else if (k >= 8'd36)  cube_r = 3'd1;
        else                  cube_r = 3'd0;
        rem36 = 6'(k - 8'(cube_r) * 8'd36);
        if (rem36 >= 6'd30)      cube_g = 3'd5;
        else if (rem36 >= 6'd24) cube_g = 3'd4;
        else if (rem36 >= 6'd18) cube_g = 3'd3;
        else if (rem36 >= 6'd12) cube_g = 3'd2;
        else if (rem36 >= 6'd6)  cube_g = 3'd1;
        else                     cube_g = 3'd0;
        cube_b = 3'(rem36 - 6'(cube_g) * 6'd6);
    end

    always_comb begin
        rgb = '{color_index, color_index, color_index};
        unique case (mode)
            pitr_pkg::MODE_GRAY: begin
                rgb = '{color_index, color_index, color_index};
            end
            pitr_pkg::MODE_SEPIA: begin
                rgb.red   = (color_index > 8'd206) ? 8'd255 : color_index + 8'd49;
                rgb.green = (color_index > 8'd227) ? 8'd255 : color_index + 8'd28;
                rgb.blue  = (color_index > 8'd150) ? color_index - 8'd105 : 8'd0;
            end
            pitr_pkg::MODE_VGA: begin
                if (color_index < 8'd16) begin
                    rgb = pitr_pkg::cga_color(color_index[3:0]);
                end else begin
                    rgb.red   = 8'(color_index[7:5]) * 8'd36;
                    rgb.green = 8'(color_index[4:2]) * 8'd36;
                    rgb.blue  = 8'(color_index[1:0]) * 8'd85;
                end
            end
            pitr_pkg::MODE_CUBE: begin
                if (color_index < 8'd16) begin
                    rgb = pitr_pkg::cga_color(color_index[3:0]);
                end else if (color_index < 8'd232) begin
                    rgb.red   = 8'(cube_r) * 8'd51;
                    rgb.green = 8'(cube_g) * 8'd51;
                    rgb.blue  = 8'(cube_b) * 8'd51;
                end else if (color_index < 8'd246) begin
                    rgb = '{gray, gray, gray};
                end else begin
                    rgb = pitr_pkg::sys_color(sys_idx);
                end
            end
            default: begin
                rgb = '{color_index, color_index, color_index};
            end
        endcase
    end

endmodule
